>>> hdl/srm_pkg.sv
// Shared types, codes and constants of the sequence and rate monitor.
package srm_pkg;

  localparam int unsigned CounterWidthDefault = 64;
  localparam int unsigned NumCounters = 12;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw = 1;
  localparam logic [63:0] Half32 = 64'h0000_0000_7FFF_FFFF;
  localparam int unsigned InDataWidth = 264;
  localparam int unsigned InUserWidth = 3;
  localparam int unsigned OutDataWidth = 72;

  typedef enum logic [2:0] {
    OP_SRC_SEQ  = 3'd0,
    OP_SRC      = 3'd1,
    OP_PUB_OK   = 3'd2,
    OP_AUX_PUB  = 3'd3,
    OP_DROP     = 3'd4,
    OP_PUB_FAIL = 3'd5,
    OP_READ     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_32   = 2'd1,
    MODE_64   = 2'd2
  } seq_mode_e;

  typedef enum logic [3:0] {
    SEL_SOURCE = 4'd0,
    SEL_PUB    = 4'd1,
    SEL_AUX    = 4'd2,
    SEL_DROP   = 4'd3,
    SEL_FAIL   = 4'd4,
    SEL_GAP    = 4'd5,
    SEL_SDUP   = 4'd6,
    SEL_SREG   = 4'd7,
    SEL_TDUP   = 4'd8,
    SEL_TREG   = 4'd9,
    SEL_LCOUNT = 4'd10,
    SEL_LSUM   = 4'd11,
    SEL_LMAX   = 4'd12,
    SEL_FIRST  = 4'd13
  } sel_e;

  typedef struct packed {
    logic        src;
    logic        seq_chk;
    logic        pub;
    logic        aux;
    logic        drop;
    logic        fail;
    logic        rd;
    logic        m32;
    logic        active;
    logic [63:0] seq;
    logic [63:0] ts;
    logic [63:0] mono;
    logic [63:0] lat;
    logic [3:0]  sel;
  } cmd_t;

  typedef struct packed {
    logic ts_regress;
    logic ts_dup;
    logic seq_regress;
    logic seq_dup;
    logic seq_gap;
  } flags_t;

endpackage

>>> hdl/srm_front.sv
// Input front end: mode register, event decode and queue push.
module srm_front
  import srm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataWidth-1:0] s_axis_tdata,
  input  logic [InUserWidth-1:0] s_axis_tuser,
  input  logic                   q_full_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  logic [1:0] mode_q, mode_d;
  op_e        op;

  assign cfg_ready_o = 1'b1;
  assign mode_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign s_axis_tready = !q_full_i;
  assign push_o = s_axis_tvalid && s_axis_tready;
  assign op = op_e'(s_axis_tuser);

  always_comb begin
    cmd_o         = '0;
    cmd_o.m32     = (mode_q == MODE_32);
    cmd_o.active  = (mode_q == MODE_32) || (mode_q == MODE_64);
    cmd_o.seq     = cmd_o.m32 ? {32'd0, s_axis_tdata[31:0]} : s_axis_tdata[63:0];
    cmd_o.ts      = s_axis_tdata[127:64];
    cmd_o.mono    = s_axis_tdata[191:128];
    cmd_o.lat     = s_axis_tdata[255:192];
    cmd_o.sel     = s_axis_tdata[259:256];
    case (op)
      OP_SRC_SEQ: begin
        cmd_o.src     = 1'b1;
        cmd_o.seq_chk = 1'b1;
      end
      OP_SRC:      cmd_o.src  = 1'b1;
      OP_PUB_OK:   cmd_o.pub  = 1'b1;
      OP_AUX_PUB:  cmd_o.aux  = 1'b1;
      OP_DROP:     cmd_o.drop = 1'b1;
      OP_PUB_FAIL: cmd_o.fail = 1'b1;
      OP_READ:     cmd_o.rd   = 1'b1;
      default:     cmd_o.src  = 1'b0;
    endcase
  end

endmodule

>>> hdl/srm_queue.sv
// Short command queue between the front end and the execution back end.
module srm_queue
  import srm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  localparam logic [QueueAw-1:0] LastPtr = QueueAw'(QueueDepth - 1);

  cmd_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   count_q, count_d;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> hdl/srm_back.sv
// Execution back end: sequence and timestamp checks, counters, result register.
module srm_back
  import srm_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    pop_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic [CounterWidth-1:0] cnt_q [NumCounters];
  logic [CounterWidth-1:0] cnt_d [NumCounters];
  logic [63:0] lmax_q, lmax_d;
  logic [63:0] first_q, first_d;
  logic [63:0] prev_seq_q, prev_seq_d;
  logic        prev_seq_valid_q, prev_seq_valid_d;
  logic [63:0] prev_ts_q, prev_ts_d;
  logic        prev_ts_valid_q, prev_ts_valid_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] rd_q, rd_d;
  flags_t      flags_q, flags_d;
  logic [63:0] expect_seq;
  logic        wrap_fwd;

  assign pop_o = q_valid_i && (!out_valid_q || m_axis_tready);

  assign expect_seq = cmd_i.m32 ? {32'd0, prev_seq_q[31:0] + 32'd1} : prev_seq_q + 64'd1;
  assign wrap_fwd   = cmd_i.m32 && (prev_seq_q > Half32) && (cmd_i.seq < Half32);

  always_comb begin
    cnt_d            = cnt_q;
    lmax_d           = lmax_q;
    first_d          = first_q;
    prev_seq_d       = prev_seq_q;
    prev_seq_valid_d = prev_seq_valid_q;
    prev_ts_d        = prev_ts_q;
    prev_ts_valid_d  = prev_ts_valid_q;
    flags_d          = '0;
    rd_d             = '0;
    if (cmd_i.seq_chk && cmd_i.active && prev_seq_valid_q) begin
      if (cmd_i.seq == prev_seq_q) begin
        flags_d.seq_dup = 1'b1;
      end else if (cmd_i.seq != expect_seq) begin
        if ((cmd_i.seq > expect_seq) || wrap_fwd) begin
          flags_d.seq_gap = 1'b1;
        end else begin
          flags_d.seq_regress = 1'b1;
        end
      end
    end
    if (cmd_i.src && prev_ts_valid_q) begin
      flags_d.ts_dup     = (cmd_i.ts == prev_ts_q);
      flags_d.ts_regress = (cmd_i.ts < prev_ts_q);
    end
    if (cmd_i.rd) begin
      if (cmd_i.sel < 4'(NumCounters)) begin
        rd_d = 64'(cnt_q[cmd_i.sel]);
      end else if (cmd_i.sel == SEL_LMAX) begin
        rd_d = lmax_q;
      end else if (cmd_i.sel == SEL_FIRST) begin
        rd_d = first_q;
      end
    end
    if (pop_o) begin
      if (cmd_i.src) begin
        if ((cmd_i.mono != '0) && (first_q == '0)) begin
          first_d = cmd_i.mono;
        end
        cnt_d[SEL_SOURCE] = cnt_q[SEL_SOURCE] + 1'b1;
        prev_ts_valid_d   = 1'b1;
        prev_ts_d         = cmd_i.ts;
      end
      if (cmd_i.seq_chk) begin
        prev_seq_valid_d = cmd_i.active;
        prev_seq_d       = cmd_i.seq;
      end
      if (flags_d.seq_gap)     cnt_d[SEL_GAP]  = cnt_q[SEL_GAP] + 1'b1;
      if (flags_d.seq_dup)     cnt_d[SEL_SDUP] = cnt_q[SEL_SDUP] + 1'b1;
      if (flags_d.seq_regress) cnt_d[SEL_SREG] = cnt_q[SEL_SREG] + 1'b1;
      if (flags_d.ts_dup)      cnt_d[SEL_TDUP] = cnt_q[SEL_TDUP] + 1'b1;
      if (flags_d.ts_regress)  cnt_d[SEL_TREG] = cnt_q[SEL_TREG] + 1'b1;
      if (cmd_i.pub) begin
        cnt_d[SEL_PUB]    = cnt_q[SEL_PUB] + 1'b1;
        cnt_d[SEL_LCOUNT] = cnt_q[SEL_LCOUNT] + 1'b1;
        cnt_d[SEL_LSUM]   = cnt_q[SEL_LSUM] + cmd_i.lat[CounterWidth-1:0];
        if (cmd_i.lat > lmax_q) begin
          lmax_d = cmd_i.lat;
        end
      end
      if (cmd_i.aux)  cnt_d[SEL_AUX]  = cnt_q[SEL_AUX] + 1'b1;
      if (cmd_i.drop) cnt_d[SEL_DROP] = cnt_q[SEL_DROP] + 1'b1;
      if (cmd_i.fail) cnt_d[SEL_FAIL] = cnt_q[SEL_FAIL] + 1'b1;
    end
    out_valid_d = pop_o || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
      lmax_q           <= '0;
      first_q          <= '0;
      prev_seq_q       <= '0;
      prev_seq_valid_q <= 1'b0;
      prev_ts_q        <= '0;
      prev_ts_valid_q  <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      cnt_q            <= cnt_d;
      lmax_q           <= lmax_d;
      first_q          <= first_d;
      prev_seq_q       <= prev_seq_d;
      prev_seq_valid_q <= prev_seq_valid_d;
      prev_ts_q        <= prev_ts_d;
      prev_ts_valid_q  <= prev_ts_valid_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q    <= rd_d;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, flags_q, rd_q};

  a_first_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_q != '0) |=> (first_q == $past(first_q)))
    else $error("first time changed after capture");

  a_seq_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.seq_chk && cmd_i.active) |=> prev_seq_valid_q)
    else $error("sequence history not marked valid");

  a_flags_src_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !cmd_i.src) |=> (flags_q == '0))
    else $error("check flag raised on a non-source event");

  a_lmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.pub) |=> (lmax_q >= $past(cmd_i.lat)))
    else $error("latency maximum below latest latency");

endmodule

>>> hdl/sequence_and_rate_monitor.sv
// Top level of the sequence and rate monitor.
//
//   channel   direction  transfer
//   cfg       in         seq_mode write (cfg_data_i[1:0])
//   s_axis    in         one event: op in tuser, operands in tdata
//   m_axis    out        one result per event: read value and check flags
//
// One event per cycle while m_axis_tready is high; events pass the queue, then the
// result register. Each event is checked and counted in the back end against its registers.
// A two-entry command queue lets the front end keep taking events while a result stalls.
// Reset clears all counters, histories, the first time and the mode; no clearing pass.
module sequence_and_rate_monitor
  import srm_pkg::*;
#(
  parameter int unsigned CounterWidth = CounterWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // seq_number, timestamp, monotonic_time, latency, counter_select, zero pad
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // op
  input  logic [InUserWidth-1:0]  s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // read_value, seq_gap_flag, seq_dup_flag, seq_regress_flag, ts_dup_flag,
  // ts_regress_flag, zero pad
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  logic q_full, push, q_valid, pop;
  cmd_t push_cmd, pop_cmd;

  srm_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  srm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (pop_cmd)
  );

  srm_back #(
    .CounterWidth (CounterWidth)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule
